### sv/brbf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brbf_pkg
// shared types, sizes and helpers for the framed byte ring buffer
// ---------------------------------------------------------------------------
package brbf_pkg;

    // buffer geometry
    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = 11;                      // count and length fields
    localparam int SUM_W     = CNT_W + 1;               // pointer plus count
    localparam int BURST_W   = $clog2(MAX_BURST + 1);

    // command queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_IDX_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // func codes on the request channel
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_FLUSH,
        OP_CLEAR
    } op_t;

    typedef enum logic {
        BK_RUN,
        BK_READ
    } back_state_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] request_length;
        logic             frame_first;
        logic             frame_last;
    } in_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic [CNT_W-1:0] done_count;
        logic             success;
        logic [CNT_W-1:0] fill_level;
        logic             last_result;
    } out_t;

    // classified command as it travels through the queue
    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [CNT_W-1:0] len;
        logic             first;
        logic             last;
    } cmd_t;

    // pointer increment with wrap at DEPTH
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/brbf_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brbf_front
// accepts requests, classifies the operation and hands a command to the queue
// ---------------------------------------------------------------------------
module brbf_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire brbf_pkg::in_t   s_data,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output brbf_pkg::cmd_t       push_cmd
);

    logic           valid_reg, valid_next;
    brbf_pkg::cmd_t cmd_reg, cmd_next;
    brbf_pkg::op_t  op_dec;

    always_comb begin
        case (s_data.func)
            brbf_pkg::FUNC_WRITE: op_dec = brbf_pkg::OP_WRITE;
            brbf_pkg::FUNC_READ:  op_dec = brbf_pkg::OP_READ;
            brbf_pkg::FUNC_FLUSH: op_dec = brbf_pkg::OP_FLUSH;
            brbf_pkg::FUNC_CLEAR: op_dec = brbf_pkg::OP_CLEAR;
            default:              op_dec = brbf_pkg::OP_CLEAR;
        endcase
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb begin
        valid_next = valid_reg && !push_ready;
        cmd_next   = cmd_reg;
        if (s_valid && s_ready) begin
            valid_next     = 1'b1;
            cmd_next.op    = op_dec;
            cmd_next.data  = s_data.data_byte;
            cmd_next.len   = s_data.request_length;
            cmd_next.first = s_data.frame_first;
            cmd_next.last  = s_data.frame_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule
`default_nettype wire

### sv/brbf_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brbf_queue
// short command queue decoupling the front from the back
// ---------------------------------------------------------------------------
module brbf_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire brbf_pkg::cmd_t  push_cmd,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output brbf_pkg::cmd_t       pop_cmd
);

    brbf_pkg::cmd_t                 slot_reg [brbf_pkg::Q_DEPTH];
    logic [brbf_pkg::Q_IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [brbf_pkg::Q_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [brbf_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign push_ready = cnt_reg != brbf_pkg::Q_CNT_W'(brbf_pkg::Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_cmd    = slot_reg[rd_idx_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_idx_next = (wr_idx_reg == brbf_pkg::Q_IDX_W'(brbf_pkg::Q_DEPTH - 1))
                        ? '0 : wr_idx_reg + brbf_pkg::Q_IDX_W'(1);
        end
        if (do_pop) begin
            rd_idx_next = (rd_idx_reg == brbf_pkg::Q_IDX_W'(brbf_pkg::Q_DEPTH - 1))
                        ? '0 : rd_idx_reg + brbf_pkg::Q_IDX_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + brbf_pkg::Q_CNT_W'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - brbf_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            slot_reg[wr_idx_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

### sv/brbf_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brbf_back
// executes commands against the byte store and drives the result register
// ---------------------------------------------------------------------------
module brbf_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire brbf_pkg::cmd_t  pop_cmd,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output brbf_pkg::out_t       m_data
);

    localparam int PW = brbf_pkg::PTR_W;
    localparam int CW = brbf_pkg::CNT_W;
    localparam int SW = brbf_pkg::SUM_W;
    localparam int BW = brbf_pkg::BURST_W;

    logic [7:0] mem [brbf_pkg::DEPTH];
    logic [7:0] mem_q;
    logic       mem_we;

    brbf_pkg::back_state_t state_reg, state_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          facc_reg, facc_next;
    logic [CW-1:0] frem_reg, frem_next;
    logic [CW-1:0] fwr_reg, fwr_next;
    logic [BW-1:0] bn_reg, bn_next;
    logic [BW-1:0] bk_reg, bk_next;
    logic          m_valid_reg, m_valid_next;
    brbf_pkg::out_t m_data_reg, m_data_next;

    logic          out_free;
    logic          full;
    logic [CW-1:0] free_sp;
    logic [CW-1:0] take;
    logic [SW-1:0] rp_sum;
    logic [BW-1:0] bk_inc;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = fill_reg == CW'(brbf_pkg::DEPTH);
    assign free_sp  = CW'(brbf_pkg::DEPTH) - fill_reg;
    assign take     = (pop_cmd.len < fill_reg) ? pop_cmd.len : fill_reg;
    assign rp_sum   = SW'(rp_reg) + SW'(take);
    assign bk_inc   = bk_reg + BW'(1);

    always_comb begin
        state_next   = state_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        facc_next    = facc_reg;
        frem_next    = frem_reg;
        fwr_next     = fwr_reg;
        bn_next      = bn_reg;
        bk_next      = bk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        pop_ready    = 1'b0;

        case (state_reg)
            brbf_pkg::BK_RUN: begin
                if (pop_valid && out_free) begin
                    pop_ready               = 1'b1;
                    m_data_next.read_byte   = '0;
                    m_data_next.success     = 1'b1;
                    m_data_next.last_result = 1'b1;
                    case (pop_cmd.op)
                        brbf_pkg::OP_WRITE: begin
                            if (pop_cmd.first) begin
                                facc_next = (free_sp != '0) && (pop_cmd.len <= free_sp);
                                frem_next = facc_next ? pop_cmd.len : '0;
                                fwr_next  = '0;
                            end
                            m_data_next.success = facc_next;
                            if (facc_next && frem_next != '0 && !full) begin
                                mem_we    = 1'b1;
                                wp_next   = brbf_pkg::ptr_inc(wp_reg);
                                fill_next = fill_reg + CW'(1);
                                frem_next = frem_next - CW'(1);
                                fwr_next  = fwr_next + CW'(1);
                            end
                            m_data_next.done_count = fwr_next;
                            m_data_next.fill_level = fill_next;
                            m_valid_next           = 1'b1;
                            if (pop_cmd.last) begin
                                facc_next = 1'b0;
                                frem_next = '0;
                                fwr_next  = '0;
                            end
                        end
                        brbf_pkg::OP_READ: begin
                            if (take == '0) begin
                                m_data_next.done_count = '0;
                                m_data_next.fill_level = fill_reg;
                                m_valid_next           = 1'b1;
                            end else begin
                                // burst length, capped at the burst limit
                                bn_next    = (take > CW'(brbf_pkg::MAX_BURST))
                                           ? BW'(brbf_pkg::MAX_BURST) : BW'(take);
                                bk_next    = '0;
                                state_next = brbf_pkg::BK_READ;
                            end
                        end
                        brbf_pkg::OP_FLUSH: begin
                            rp_next = (rp_sum >= SW'(brbf_pkg::DEPTH))
                                    ? PW'(rp_sum - SW'(brbf_pkg::DEPTH)) : PW'(rp_sum);
                            fill_next              = fill_reg - take;
                            m_data_next.done_count = take;
                            m_data_next.fill_level = fill_next;
                            m_valid_next           = 1'b1;
                        end
                        brbf_pkg::OP_CLEAR: begin
                            rp_next                = '0;
                            wp_next                = '0;
                            fill_next              = '0;
                            facc_next              = 1'b0;
                            frem_next              = '0;
                            fwr_next               = '0;
                            m_data_next.done_count = '0;
                            m_data_next.fill_level = '0;
                            m_valid_next           = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            brbf_pkg::BK_READ: begin
                // mem_q holds the byte at the read pointer
                if (out_free) begin
                    rp_next                 = brbf_pkg::ptr_inc(rp_reg);
                    fill_next               = fill_reg - CW'(1);
                    bk_next                 = bk_inc;
                    m_data_next.read_byte   = mem_q;
                    m_data_next.done_count  = CW'(bk_inc);
                    m_data_next.success     = 1'b1;
                    m_data_next.fill_level  = fill_next;
                    m_data_next.last_result = bk_inc == bn_reg;
                    m_valid_next            = 1'b1;
                    if (bk_inc == bn_reg) begin
                        state_next = brbf_pkg::BK_RUN;
                    end
                end
            end
            default: begin
                state_next = brbf_pkg::BK_RUN;
            end
        endcase
    end

    // byte store: read address follows the next read pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= pop_cmd.data;
        end
        mem_q <= mem[rp_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= brbf_pkg::BK_RUN;
            rp_reg      <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            facc_reg    <= 1'b0;
            frem_reg    <= '0;
            fwr_reg     <= '0;
            bn_reg      <= '0;
            bk_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            facc_reg    <= facc_next;
            frem_reg    <= frem_next;
            fwr_reg     <= fwr_next;
            bn_reg      <= bn_next;
            bk_reg      <= bk_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

### sv/byte_ring_buffer_frames_unit.sv
`default_nettype none
// a request passes the front register and the command queue to the result register;
// the first byte of a read also waits for the BK_READ state and the registered store read
// throughput: writes, flushes, clears and empty reads sustain one request per cycle
// while the result channel takes every result; a read holds the back end in BK_READ
// until its burst is out, a byte at a time through the single read port of the byte store
// reset: synchronous, active low; empties the buffer and drops queued requests,
// store contents stay undefined and get no clearing pass
// ---------------------------------------------------------------------------
// byte_ring_buffer_frames_unit
// framed byte ring buffer: whole-frame writes, burst reads, flush and clear
// ---------------------------------------------------------------------------
module byte_ring_buffer_frames_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // request channel
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire brbf_pkg::in_t   s_data,
    // result channel
    output logic                 m_valid,
    input  wire logic            m_ready,
    output brbf_pkg::out_t       m_data
);

    // front to queue
    logic           push_valid;
    logic           push_ready;
    brbf_pkg::cmd_t push_cmd;

    // queue to back
    logic           pop_valid;
    logic           pop_ready;
    brbf_pkg::cmd_t pop_cmd;

    // front: takes a request, decodes func into an operation, holds it
    // in a single register until the queue has room
    brbf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // two-entry queue so the front keeps accepting while a read burst
    // or a stalled result holds the back end
    brbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // back: owns pointers, fill count, frame tracking and the byte store;
    // one command at a time, results through an output register
    brbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the framed byte ring buffer: a queued request
// driver, a result collector with random back-pressure, and a request-level
// shadow of the buffer that predicts every result and its order
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 40;    // request count that starts the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_REQS = 136;
    localparam int SETTLE      = 20;

    logic           aclk;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    brbf_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    brbf_pkg::out_t m_data;

    byte_ring_buffer_frames_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // shadow of the buffer
    // ------------------------------------------------------------------
    logic [7:0]     ring_copy [brbf_pkg::DEPTH];    // entries are only read after being written
    int             rd_idx      = 0;
    int             wr_idx      = 0;
    bit             ring_full   = 1'b0;
    bit             frame_open  = 1'b0;
    int             frame_left  = 0;
    int             frame_count = 0;
    brbf_pkg::out_t due_results [$];     // results owed by the block, oldest first

    function automatic int stored_bytes();
        if (ring_full) begin
            return brbf_pkg::DEPTH;
        end
        if (wr_idx >= rd_idx) begin
            return wr_idx - rd_idx;
        end
        return wr_idx + brbf_pkg::DEPTH - rd_idx;
    endfunction

    function automatic int step_idx(input int p);
        return (p == brbf_pkg::DEPTH - 1) ? 0 : p + 1;
    endfunction

    // fill level is taken after the state change that the result reports
    task automatic owe_result(input logic [7:0] b, input int done, input bit ok,
                              input bit fin);
        brbf_pkg::out_t o;
        o.read_byte   = b;
        o.done_count  = brbf_pkg::CNT_W'(done);
        o.success     = ok;
        o.fill_level  = brbf_pkg::CNT_W'(stored_bytes());
        o.last_result = fin;
        due_results.push_back(o);
    endtask

    // advance the shadow by one accepted request and queue what it produces
    task automatic apply_request(input brbf_pkg::in_t r);
        int         room;
        int         n;
        int         k;
        int         len;
        logic [7:0] b;
        len = int'(r.request_length);
        case (r.func)
            brbf_pkg::FUNC_WRITE: begin
                // a first byte re-runs the space check and drops any open frame
                if (r.frame_first) begin
                    room        = brbf_pkg::DEPTH - stored_bytes();
                    frame_open  = (room != 0) && (len <= room);
                    frame_left  = frame_open ? len : 0;
                    frame_count = 0;
                end
                // bytes past the declared length fall on the floor
                if (frame_open && frame_left > 0 && !ring_full) begin
                    ring_copy[wr_idx] = r.data_byte;
                    wr_idx      = step_idx(wr_idx);
                    ring_full   = (wr_idx == rd_idx);
                    frame_left  = frame_left - 1;
                    frame_count = frame_count + 1;
                end
                owe_result(8'h00, frame_count, frame_open, 1'b1);
                if (r.frame_last) begin
                    frame_open  = 1'b0;
                    frame_left  = 0;
                    frame_count = 0;
                end
            end
            brbf_pkg::FUNC_READ: begin
                n = stored_bytes();
                if (len < n) begin
                    n = len;
                end
                if (n > brbf_pkg::MAX_BURST) begin
                    n = brbf_pkg::MAX_BURST;
                end
                if (n == 0) begin
                    owe_result(8'h00, 0, 1'b1, 1'b1);
                end else begin
                    for (k = 0; k < n; k++) begin
                        b         = ring_copy[rd_idx];
                        rd_idx    = step_idx(rd_idx);
                        ring_full = 1'b0;
                        owe_result(b, k + 1, 1'b1, k + 1 == n);
                    end
                end
            end
            brbf_pkg::FUNC_FLUSH: begin
                n = stored_bytes();
                if (len < n) begin
                    n = len;
                end
                if (n > 0) begin
                    rd_idx = rd_idx + n;
                    if (rd_idx >= brbf_pkg::DEPTH) begin
                        rd_idx = rd_idx - brbf_pkg::DEPTH;
                    end
                    ring_full = 1'b0;
                end
                owe_result(8'h00, n, 1'b1, 1'b1);
            end
            default: begin
                // clear: pointers home, frame closed
                rd_idx      = 0;
                wr_idx      = 0;
                ring_full   = 1'b0;
                frame_open  = 1'b0;
                frame_left  = 0;
                frame_count = 0;
                owe_result(8'h00, 0, 1'b1, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request driver, fed from the pending queues
    // ------------------------------------------------------------------
    brbf_pkg::in_t pending_reqs [$];
    int            pending_gaps [$];     // idle cycles after each request
    bit            pending_drain [$];    // hold this request until nothing is owed
    int            idle_left = 0;

    always @(posedge aclk) begin : drive_requests
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_data);
            end
            // a request not yet taken stays on the bus untouched
            offer = s_valid && !s_ready;
            if (!offer) begin
                if (idle_left > 0) begin
                    idle_left = idle_left - 1;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_drain[0] && due_results.size() != 0)) begin
                    offer = 1'b1;
                    s_data <= pending_reqs.pop_front();
                    void'(pending_drain.pop_front());
                    idle_left = pending_gaps.pop_front();
                end
            end
            s_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off: starts once, on a fixed request count, so the
    // block backs up while the driver keeps offering
    // ------------------------------------------------------------------
    int taken_reqs = 0;
    int hold_left  = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_reqs <= taken_reqs + 1;
            end
            if (s_valid && s_ready && taken_reqs == HOLD_AT) begin
                hold_left <= HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result collector and checker
    // ------------------------------------------------------------------
    int   errors       = 0;
    int   results_seen = 0;
    int   stall_left   = 0;

    always @(posedge aclk) begin : collect_results
        logic           take;
        brbf_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) begin
                        $display("extra result %0d: byte %02h cnt %0d ok %0d fill %0d last %0d",
                                 results_seen, m_data.read_byte, m_data.done_count,
                                 m_data.success, m_data.fill_level, m_data.last_result);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (m_data.read_byte !== want.read_byte ||
                        m_data.done_count !== want.done_count ||
                        m_data.success !== want.success ||
                        m_data.fill_level !== want.fill_level ||
                        m_data.last_result !== want.last_result) begin
                        errors = errors + 1;
                        if (errors <= 10) begin
                            $display("result %0d want: byte %02h cnt %0d ok %0d fill %0d last %0d",
                                     results_seen, want.read_byte, want.done_count,
                                     want.success, want.fill_level, want.last_result);
                            $display("    got byte %02h cnt %0d ok %0d fill %0d last %0d",
                                     m_data.read_byte, m_data.done_count, m_data.success,
                                     m_data.fill_level, m_data.last_result);
                        end
                    end
                end
                results_seen = results_seen + 1;
                // every fourth stretch of 50 results runs without stalls
                stall_left = (((results_seen / 50) % 4) == 1) ? 0 : $urandom_range(0, 13);
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                take = 1'b0;
            end else begin
                take = (hold_left == 0);
            end
            m_ready <= take;
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int planned    = 0;
    int idle_max   = 13;
    bit drain_next = 1'b0;

    task automatic queue_request(input logic [1:0] f, input logic [7:0] d, input int len,
                                 input bit first, input bit last);
        brbf_pkg::in_t r;
        r.func           = f;
        r.data_byte      = d;
        r.request_length = brbf_pkg::CNT_W'(len);
        r.frame_first    = first;
        r.frame_last     = last;
        pending_reqs.push_back(r);
        pending_gaps.push_back($urandom_range(0, idle_max));
        pending_drain.push_back(drain_next);
        drain_next = 1'b0;
        planned    = planned + 1;
    endtask

    // write frame with random bytes; length fields of non-first bytes are noise
    task automatic queue_frame(input int decl, input int nbytes, input bit close);
        int i;
        for (i = 0; i < nbytes; i++) begin
            queue_request(brbf_pkg::FUNC_WRITE, 8'($urandom),
                          (i == 0) ? decl : $urandom_range(0, 2047),
                          i == 0, close && (i == nbytes - 1));
        end
    endtask

    initial begin : run_test
        int  pick;
        int  decl;
        int  nbytes;
        int  stop_at;

        // directed: empty answers
        queue_request(brbf_pkg::FUNC_READ, 8'h00, 5, 1'b0, 1'b0);
        queue_request(brbf_pkg::FUNC_FLUSH, 8'hFF, 2047, 1'b1, 1'b1);
        // stray byte outside any frame
        queue_request(brbf_pkg::FUNC_WRITE, 8'hFF, 0, 1'b0, 1'b0);
        // frame of 3 with one byte too many
        queue_request(brbf_pkg::FUNC_WRITE, 8'h00, 3, 1'b1, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'hFF, 2047, 1'b0, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'hA5, 0, 1'b0, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'h5A, 1024, 1'b0, 1'b1);
        // zero-length frame still passes the space check
        queue_request(brbf_pkg::FUNC_WRITE, 8'h7E, 0, 1'b1, 1'b1);
        // oversize declaration rejects the whole frame
        queue_request(brbf_pkg::FUNC_WRITE, 8'h11, 2047, 1'b1, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'h22, 0, 1'b0, 1'b1);
        // a new first byte abandons the open frame
        queue_request(brbf_pkg::FUNC_WRITE, 8'h33, 4, 1'b1, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'h44, 2, 1'b1, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'h55, 2, 1'b0, 1'b1);
        // partial read, partial flush, then drain all
        queue_request(brbf_pkg::FUNC_READ, 8'h00, 2, 1'b0, 1'b0);
        queue_request(brbf_pkg::FUNC_FLUSH, 8'h00, 1, 1'b0, 1'b0);
        queue_request(brbf_pkg::FUNC_READ, 8'hFF, 2047, 1'b1, 1'b0);
        // clear closes an open frame, next byte is stray
        queue_request(brbf_pkg::FUNC_WRITE, 8'h66, 2, 1'b1, 1'b0);
        queue_request(brbf_pkg::FUNC_CLEAR, 8'hFF, 2047, 1'b1, 1'b1);
        queue_request(brbf_pkg::FUNC_WRITE, 8'h77, 0, 1'b0, 1'b1);
        // full-size declaration on an empty buffer
        queue_request(brbf_pkg::FUNC_WRITE, 8'h88, 1024, 1'b1, 1'b0);
        queue_request(brbf_pkg::FUNC_WRITE, 8'h99, 0, 1'b0, 1'b1);
        // zero-byte read on a non-empty buffer, then flush the rest
        queue_request(brbf_pkg::FUNC_READ, 8'h00, 0, 1'b0, 1'b0);
        queue_request(brbf_pkg::FUNC_FLUSH, 8'h00, 1024, 1'b0, 1'b0);

        // random: mostly well-formed frames and reads, some noise;
        // the sender waits for a quiet block before the first one
        drain_next = 1'b1;
        stop_at    = planned + RANDOM_REQS;
        while (planned < stop_at) begin
            // alternate stretches with and without sender gaps
            idle_max = (((planned / 20) % 3) == 0) ? 0 : 13;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                decl   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, 24);
                nbytes = (decl > 24) ? $urandom_range(1, 4) : decl + $urandom_range(0, 2) - 1;
                if (nbytes < 1) begin
                    nbytes = 1;
                end
                queue_frame(decl, nbytes, $urandom_range(0, 7) != 0);
            end else if (pick < 75) begin
                queue_request(brbf_pkg::FUNC_READ, 8'($urandom),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                          : $urandom_range(0, 80),
                              1'($urandom), 1'($urandom));
            end else if (pick < 85) begin
                queue_request(brbf_pkg::FUNC_FLUSH, 8'($urandom),
                              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
                                                          : $urandom_range(0, 16),
                              1'($urandom), 1'($urandom));
            end else if (pick < 88) begin
                queue_request(brbf_pkg::FUNC_CLEAR, 8'($urandom), $urandom_range(0, 2047),
                              1'($urandom), 1'($urandom));
            end else begin
                // noise: raw write bytes with arbitrary flags and lengths
                queue_request(brbf_pkg::FUNC_WRITE, 8'($urandom), $urandom_range(0, 2047),
                              1'($urandom), 1'($urandom));
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || due_results.size() != 0) begin
            @(posedge aclk);
        end
        // catch stray results after the last owed one
        repeat (SETTLE) @(posedge aclk);
        errors = errors + due_results.size();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
